>>> hw/rtl/obbq_pkg.sv
// Shared constants for the oriented-box point query: register layout, indexes and opcodes.
package obbq_pkg;

    // Configuration register widths (fixed by the register map)
    localparam int CENTER_REG_W = 60;
    localparam int EXTENT_REG_W = 60;
    localparam int AXIS_REG_W   = 48;
    localparam int CFG_DATA_W   = 60;
    localparam int CFG_IDX_W    = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOX_CENTER   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_EXTENTS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_ZERO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_ONE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_TWO     = 3'd4;

    // Operation codes
    localparam logic OP_CLOSEST = 1'b0;
    localparam logic OP_SUPPORT = 1'b1;

endpackage

>>> hw/rtl/obbq_mac3.sv
// Two-stage three-term signed multiply-accumulate: register products, then register their sum.
module obbq_mac3 #(
    parameter int A_W = 21,
    parameter int B_W = 16
) (
    input  logic                     clk,
    input  logic signed [A_W-1:0]    a0,
    input  logic signed [A_W-1:0]    a1,
    input  logic signed [A_W-1:0]    a2,
    input  logic signed [B_W-1:0]    b0,
    input  logic signed [B_W-1:0]    b1,
    input  logic signed [B_W-1:0]    b2,
    output logic signed [A_W+B_W+1:0] sum
);

    localparam int PW = A_W + B_W;

    logic signed [PW-1:0]     prod0_reg;
    logic signed [PW-1:0]     prod1_reg;
    logic signed [PW-1:0]     prod2_reg;
    logic signed [PW+1:0]     sum_reg;

    // Products carry no control state: no reset
    always_ff @(posedge clk)
    begin
        prod0_reg <= a0 * b0;
        prod1_reg <= a1 * b1;
        prod2_reg <= a2 * b2;
        sum_reg   <= (PW+2)'(prod0_reg) + (PW+2)'(prod1_reg) + (PW+2)'(prod2_reg);
    end

    assign sum = sum_reg;

endmodule

>>> hw/rtl/obb_point_query.sv
// Top level of the oriented-box point query pipeline.
//
// Usage:
//   Load the box with the write port (wr_en, wr_index, wr_data): center, half extents
//   and three axis rows. Write only while no transaction is in flight.
//   Issue a query by raising start with operation and vec_x/y/z; busy never rises,
//   so one transaction is taken on every cycle that start is high.
//   Operation closest: returns the closest point on the box and inside_res.
//   Operation support: returns the box corner farthest along the direction,
//   inside_res low.
// Pipeline and throughput:
//   done marks a result on point_x/y/z and inside_res; each result holds for one cycle.
//   Eight register stages set the latency: difference, projection products and sum,
//   clamp and round, rebuild products and sum, round, center add with saturation.
//   Every stage advances on every cycle, so one transaction per cycle is sustained.
// Reset:
//   rst_n clears all valid bits and returns the box to center zero, extents zero and
//   identity axes. The receiver cannot stall, so the pipeline never holds.
module obb_point_query
    import obbq_pkg::*;
#(
    parameter int COORD_WIDTH = 20,
    parameter int AXIS_WIDTH  = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          operation,
    input  logic signed [COORD_WIDTH-1:0] vec_x,
    input  logic signed [COORD_WIDTH-1:0] vec_y,
    input  logic signed [COORD_WIDTH-1:0] vec_z,
    input  logic                          wr_en,
    input  logic [CFG_IDX_W-1:0]          wr_index,
    input  logic [CFG_DATA_W-1:0]         wr_data,
    output logic                          done,
    output logic signed [COORD_WIDTH-1:0] point_x,
    output logic signed [COORD_WIDTH-1:0] point_y,
    output logic signed [COORD_WIDTH-1:0] point_z,
    output logic                          inside_res
);

    localparam int CW    = COORD_WIDTH;
    localparam int AW    = AXIS_WIDTH;
    localparam int FRAC  = AW - 2;
    localparam int DW    = CW + 1;           // difference and coefficient width
    localparam int DOTW  = DW + AW + 2;      // three-term sum width
    localparam int RW    = DOTW - FRAC;      // rounded rebuild width
    localparam int TW    = RW + 1;           // center plus offset
    localparam int DEPTH = 8;

    localparam logic signed [DOTW-1:0] HALF_LSB = DOTW'(64'sd1 <<< (FRAC - 1));
    localparam logic signed [TW-1:0]   SAT_HI   = TW'((64'sd1 <<< (CW - 1)) - 64'sd1);
    localparam logic signed [TW-1:0]   SAT_LO   = -SAT_HI - TW'(1);

    localparam logic [AXIS_REG_W-1:0] AXIS0_RST = AXIS_REG_W'(64'd1 << FRAC);
    localparam logic [AXIS_REG_W-1:0] AXIS1_RST = AXIS_REG_W'(64'd1 << (FRAC + AW));
    localparam logic [AXIS_REG_W-1:0] AXIS2_RST = AXIS_REG_W'(64'd1 << (FRAC + 2 * AW));

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CENTER_REG_W-1:0] center_reg;
    logic [EXTENT_REG_W-1:0] extent_reg;
    logic [AXIS_REG_W-1:0]   axis0_reg;
    logic [AXIS_REG_W-1:0]   axis1_reg;
    logic [AXIS_REG_W-1:0]   axis2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_reg <= '0;
            extent_reg <= '0;
            axis0_reg  <= AXIS0_RST;
            axis1_reg  <= AXIS1_RST;
            axis2_reg  <= AXIS2_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_BOX_CENTER:   center_reg <= wr_data[CENTER_REG_W-1:0];
                REG_HALF_EXTENTS: extent_reg <= wr_data[EXTENT_REG_W-1:0];
                REG_AXIS_ZERO:    axis0_reg  <= wr_data[AXIS_REG_W-1:0];
                REG_AXIS_ONE:     axis1_reg  <= wr_data[AXIS_REG_W-1:0];
                REG_AXIS_TWO:     axis2_reg  <= wr_data[AXIS_REG_W-1:0];
                default:          ; // drop writes beyond the map
            endcase
        end
    end

    // Unpack components; fields beyond the register width read as zero
    logic [63:0]                   center_pad;
    logic [63:0]                   extent_pad;
    logic [63:0]                   axis_pad [3];
    logic signed [CW-1:0]          cen [3];
    logic [CW-1:0]                 ext [3];
    logic signed [AW-1:0]          ax  [3][3];   // ax[row][component]

    assign center_pad  = 64'(center_reg);
    assign extent_pad  = 64'(extent_reg);
    assign axis_pad[0] = 64'(axis0_reg);
    assign axis_pad[1] = 64'(axis1_reg);
    assign axis_pad[2] = 64'(axis2_reg);

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            cen[j] = center_pad[j*CW +: CW];
            ext[j] = extent_pad[j*CW +: CW];
            for (int i = 0; i < 3; i++)
            begin
                ax[i][j] = axis_pad[i][j*AW +: AW];
            end
        end
    end

    // ------------------------------------------------------------------
    // Valid and opcode travel along the pipeline
    // ------------------------------------------------------------------
    logic [DEPTH-1:0] vld_reg;
    logic [2:0]       op_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], start};
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= {op_reg[1:0], operation};
    end

    // ------------------------------------------------------------------
    // Stage 1: offset from center for point queries, raw direction otherwise
    // ------------------------------------------------------------------
    logic signed [DW-1:0] diff_reg [3];
    logic signed [CW-1:0] vin [3];

    assign vin[0] = vec_x;
    assign vin[1] = vec_y;
    assign vin[2] = vec_z;

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            if (operation == OP_CLOSEST)
            begin
                diff_reg[j] <= DW'(vin[j]) - DW'(cen[j]);
            end
            else
            begin
                diff_reg[j] <= DW'(vin[j]);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stages 2-3: projection onto each axis row
    // ------------------------------------------------------------------
    logic signed [DOTW-1:0] dot [3];

    for (genvar gi = 0; gi < 3; gi++)
    begin : g_proj
        obbq_mac3 #(
            .A_W (DW),
            .B_W (AW)
        ) u_proj (
            .clk (clk),
            .a0  (diff_reg[0]),
            .a1  (diff_reg[1]),
            .a2  (diff_reg[2]),
            .b0  (ax[gi][0]),
            .b1  (ax[gi][1]),
            .b2  (ax[gi][2]),
            .sum (dot[gi])
        );
    end

    // ------------------------------------------------------------------
    // Stage 4: clamp to the extent and round, or pick the support side
    // ------------------------------------------------------------------
    logic signed [DW-1:0]   coef_next [3];
    logic signed [DW-1:0]   coef_reg  [3];
    logic                   inside_next;
    logic                   inside_reg;
    logic signed [DOTW-1:0] lim       [3];
    logic signed [DOTW-1:0] clamped   [3];
    logic signed [DOTW-1:0] rounded   [3];
    logic signed [DW-1:0]   ext_s     [3];

    always_comb
    begin
        inside_next = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            lim[i]   = {{(DOTW-CW-FRAC){1'b0}}, ext[i], {FRAC{1'b0}}};
            ext_s[i] = {1'b0, ext[i]};
            if (dot[i] > lim[i])
            begin
                clamped[i]  = lim[i];
                inside_next = 1'b0;
            end
            else if (dot[i] < -lim[i])
            begin
                clamped[i]  = -lim[i];
                inside_next = 1'b0;
            end
            else
            begin
                clamped[i] = dot[i];
            end
            rounded[i] = (clamped[i] + HALF_LSB) >>> FRAC;
            if (op_reg[2] == OP_CLOSEST)
            begin
                coef_next[i] = rounded[i][DW-1:0];
            end
            else
            begin
                // zero dot product takes the positive side
                coef_next[i] = (dot[i] >= 0) ? ext_s[i] : -ext_s[i];
            end
        end
        if (op_reg[2] != OP_CLOSEST)
        begin
            inside_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            coef_reg[i] <= coef_next[i];
        end
        inside_reg <= inside_next;
    end

    // Hold the containment flag alongside the rebuild stages
    logic [2:0] inside_dly_reg;

    always_ff @(posedge clk)
    begin
        inside_dly_reg <= {inside_dly_reg[1:0], inside_reg};
    end

    // ------------------------------------------------------------------
    // Stages 5-6: rebuild the offset as the weighted sum of axis rows
    // ------------------------------------------------------------------
    logic signed [DOTW-1:0] acc [3];

    for (genvar gj = 0; gj < 3; gj++)
    begin : g_rebuild
        obbq_mac3 #(
            .A_W (DW),
            .B_W (AW)
        ) u_rebuild (
            .clk (clk),
            .a0  (coef_reg[0]),
            .a1  (coef_reg[1]),
            .a2  (coef_reg[2]),
            .b0  (ax[0][gj]),
            .b1  (ax[1][gj]),
            .b2  (ax[2][gj]),
            .sum (acc[gj])
        );
    end

    // ------------------------------------------------------------------
    // Stage 7: round the offset to coordinate format
    // ------------------------------------------------------------------
    logic signed [DOTW-1:0] acc_rnd [3];
    logic signed [RW-1:0]   offs_reg [3];

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            acc_rnd[j] = (acc[j] + HALF_LSB) >>> FRAC;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            offs_reg[j] <= acc_rnd[j][RW-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Stage 8: add the center and saturate
    // ------------------------------------------------------------------
    logic signed [TW-1:0] total [3];
    logic signed [CW-1:0] sat_next [3];
    logic signed [CW-1:0] point_reg [3];
    logic                 inside_out_reg;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            total[j] = TW'(offs_reg[j]) + TW'(cen[j]);
            if (total[j] > SAT_HI)
            begin
                sat_next[j] = SAT_HI[CW-1:0];
            end
            else if (total[j] < SAT_LO)
            begin
                sat_next[j] = SAT_LO[CW-1:0];
            end
            else
            begin
                sat_next[j] = total[j][CW-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < 3; j++)
        begin
            point_reg[j] <= sat_next[j];
        end
        inside_out_reg <= inside_dly_reg[2];
    end

    assign done       = vld_reg[DEPTH-1];
    assign point_x    = point_reg[0];
    assign point_y    = point_reg[1];
    assign point_z    = point_reg[2];
    assign inside_res = inside_out_reg;

endmodule

>>> dv/obb_point_query_tb.sv
// Self-checking testbench for the oriented-box point query: closest and support points.
module obb_point_query_tb
    import obbq_pkg::*;
();

    // Widths and fixed-point scale used by the instance (block defaults)
    localparam int COORD_W    = 20;
    localparam int AXIS_W     = 16;
    localparam int AXIS_FRAC  = AXIS_W - 2;
    localparam int PIPE_DEPTH = 8;
    localparam int CYCLE_LIMIT = 200000;

    localparam longint ONE        = 256;                      // 1.0 in Q12.8
    localparam longint UNIT_AXIS  = longint'(1) << AXIS_FRAC; // 1.0 in Q2.14
    localparam longint DIAG_AXIS  = 11585;                    // cos(45 deg) in Q2.14
    localparam longint AXIS_MAX   = (longint'(1) << (AXIS_W - 1)) - 1;
    localparam longint AXIS_MIN   = -(longint'(1) << (AXIS_W - 1));
    localparam longint COORD_MAX  = (longint'(1) << (COORD_W - 1)) - 1;
    localparam longint COORD_MIN  = -(longint'(1) << (COORD_W - 1));
    localparam longint EXTENT_MAX = (longint'(1) << COORD_W) - 1;
    localparam longint ROUND_HALF = longint'(1) << (AXIS_FRAC - 1);

    // Indexes past the register list; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_AXIS_TWO + 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = '1;

    // One query transaction plus its pacing: idle cycles ahead of it, and whether
    // to hold it back until every outstanding result has returned.
    typedef struct packed {
        logic                      op;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        int                        gap;
        bit                        drain;
    } query_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic                      in_box;
    } box_point_t;

    logic                      clk        = 1'b0;
    logic                      rst_n      = 1'b0;
    logic                      start      = 1'b0;
    logic                      operation  = 1'b0;
    logic signed [COORD_W-1:0] vec_x      = '0;
    logic signed [COORD_W-1:0] vec_y      = '0;
    logic signed [COORD_W-1:0] vec_z      = '0;
    logic                      wr_en      = 1'b0;
    logic [CFG_IDX_W-1:0]      wr_index   = '0;
    logic [CFG_DATA_W-1:0]     wr_data    = '0;
    logic                      busy;
    logic                      done;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic                      inside_res;

    // Shadow copy of the box registers, starting from their reset values
    logic [CENTER_REG_W-1:0] box_center_q   = '0;
    logic [EXTENT_REG_W-1:0] half_extents_q = '0;
    logic [AXIS_REG_W-1:0]   axis_rows_q [3] = '{48'h0000_0000_4000,
                                                 48'h0000_4000_0000,
                                                 48'h4000_0000_0000};

    query_t     query_backlog [$];   // transactions waiting for the driver
    box_point_t expected_points [$]; // predicted results, oldest first

    query_t     active_query;
    box_point_t want_point;
    int         gap_left;
    bit         gap_loaded;
    bit         launch;
    int         mismatch_count = 0;
    int         cycle_count    = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    obb_point_query #(
        .COORD_WIDTH(COORD_W),
        .AXIS_WIDTH (AXIS_W)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .operation (operation),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .wr_en     (wr_en),
        .wr_index  (wr_index),
        .wr_data   (wr_data),
        .done      (done),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .inside_res(inside_res)
    );

    // ---------------------------------------------------------------------------
    // Field access on the shadow registers (x in the lowest bits)
    // ---------------------------------------------------------------------------
    function automatic longint center_of(int j);
        center_of = $signed(box_center_q[j*COORD_W +: COORD_W]);
    endfunction

    // Extents are magnitudes: a set top bit means large, never negative
    function automatic longint extent_of(int j);
        extent_of = half_extents_q[j*COORD_W +: COORD_W];
    endfunction

    function automatic longint axis_of(int i, int j);
        axis_of = $signed(axis_rows_q[i][j*AXIS_W +: AXIS_W]);
    endfunction

    // ---------------------------------------------------------------------------
    // Predict the point and containment flag for one query under the current box.
    // Projections stay exact (Q.22); clamping and the containment test use them
    // unrounded. Closest-point coefficients and the rebuilt offset round half up,
    // then add the center and saturate per coordinate.
    // ---------------------------------------------------------------------------
    function automatic box_point_t predict_query(query_t q);
        longint     vec [3];
        longint     coef [3];
        longint     dot;
        longint     lim;
        longint     acc;
        longint     sum;
        longint     diff;
        bit         in_box;
        int         i;
        int         j;
        box_point_t r;
        vec[0] = q.x;
        vec[1] = q.y;
        vec[2] = q.z;
        in_box = 1'b1;
        for (i = 0; i < 3; i++)
        begin
            lim = extent_of(i) <<< AXIS_FRAC;
            dot = 0;
            for (j = 0; j < 3; j++)
            begin
                diff = (q.op == OP_CLOSEST) ? vec[j] - center_of(j) : vec[j];
                dot += diff * axis_of(i, j);
            end
            if (q.op == OP_CLOSEST)
            begin
                if (dot > lim || dot < -lim)
                    in_box = 1'b0;
                if (dot > lim)
                    dot = lim;
                else if (dot < -lim)
                    dot = -lim;
                coef[i] = (dot + ROUND_HALF) >>> AXIS_FRAC;
            end
            else
            begin
                // A zero dot product picks the positive side
                coef[i] = (dot >= 0) ? extent_of(i) : -extent_of(i);
            end
        end
        for (j = 0; j < 3; j++)
        begin
            acc = 0;
            for (i = 0; i < 3; i++)
                acc += axis_of(i, j) * coef[i];
            sum = center_of(j) + ((acc + ROUND_HALF) >>> AXIS_FRAC);
            if (sum > COORD_MAX)
                sum = COORD_MAX;
            else if (sum < COORD_MIN)
                sum = COORD_MIN;
            case (j)
                0: r.x = sum[COORD_W-1:0];
                1: r.y = sum[COORD_W-1:0];
                default: r.z = sum[COORD_W-1:0];
            endcase
        end
        r.in_box = (q.op == OP_CLOSEST) && in_box;
        return r;
    endfunction

    // ---------------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------------
    function automatic logic [CFG_DATA_W-1:0] pack_coords(longint x, longint y, longint z);
        pack_coords = {z[COORD_W-1:0], y[COORD_W-1:0], x[COORD_W-1:0]};
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pack_axis(longint x, longint y, longint z);
        pack_axis = {x[AXIS_W-1:0]} | ({y[AXIS_W-1:0]} << AXIS_W)
                  | ({z[AXIS_W-1:0]} << (2 * AXIS_W));
    endfunction

    function automatic query_t mk_query(logic op, longint x, longint y, longint z);
        query_t q;
        q.op    = op;
        q.x     = x[COORD_W-1:0];
        q.y     = y[COORD_W-1:0];
        q.z     = z[COORD_W-1:0];
        q.gap   = 0;
        q.drain = 1'b0;
        return q;
    endfunction

    function automatic longint rand_span(longint lo, longint hi);
        rand_span = lo + longint'($urandom_range(0, int'(hi - lo)));
    endfunction

    function automatic longint pick_coord_extreme();
        case ($urandom_range(0, 4))
            0: pick_coord_extreme = COORD_MAX;
            1: pick_coord_extreme = COORD_MIN;
            2: pick_coord_extreme = 0;
            3: pick_coord_extreme = -1;
            default: pick_coord_extreme = 1;
        endcase
    endfunction

    // Drive one register write and mirror it in the shadow copy. Only called while
    // nothing is in flight, so the shadow can change ahead of the write edge.
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        case (idx)
            REG_BOX_CENTER:   box_center_q   = data[CENTER_REG_W-1:0];
            REG_HALF_EXTENTS: half_extents_q = data[EXTENT_REG_W-1:0];
            REG_AXIS_ZERO:    axis_rows_q[0] = data[AXIS_REG_W-1:0];
            REG_AXIS_ONE:     axis_rows_q[1] = data[AXIS_REG_W-1:0];
            REG_AXIS_TWO:     axis_rows_q[2] = data[AXIS_REG_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        wr_en <= 1'b0;
    endtask

    task automatic load_box(logic [CFG_DATA_W-1:0] center, logic [CFG_DATA_W-1:0] extents,
                            logic [CFG_DATA_W-1:0] row0, logic [CFG_DATA_W-1:0] row1,
                            logic [CFG_DATA_W-1:0] row2);
        write_reg(REG_BOX_CENTER, center);
        write_reg(REG_HALF_EXTENTS, extents);
        write_reg(REG_AXIS_ZERO, row0);
        write_reg(REG_AXIS_ONE, row1);
        write_reg(REG_AXIS_TWO, row2);
    endtask

    // Pick a new box. Half are well formed (signed permuted axes, maybe turned
    // 45 degrees in one plane); the rest have raw bits, non-unit axes or extremes.
    task automatic load_random_box();
        int                    style;
        int                    i;
        int                    j;
        int                    col [3];
        longint                row [3][3];
        longint                cv [3];
        longint                ev [3];
        logic [CFG_DATA_W-1:0] raw_center;
        logic [CFG_DATA_W-1:0] raw_extents;
        logic [CFG_IDX_W-1:0]  spare;
        style  = $urandom_range(0, 5);
        col[0] = $urandom_range(0, 2);
        col[1] = (col[0] + 1 + $urandom_range(0, 1)) % 3;
        col[2] = 3 - col[0] - col[1];
        for (i = 0; i < 3; i++)
        begin
            cv[i] = rand_span(-(longint'(1) << 17), longint'(1) << 17);
            ev[i] = ($urandom_range(0, 9) == 0) ? 0 : rand_span(0, 4096);
            for (j = 0; j < 3; j++)
                row[i][j] = (j == col[i]) ? ($urandom_range(0, 1) ? UNIT_AXIS : -UNIT_AXIS) : 0;
        end
        if (style == 1)
        begin
            // Turn rows zero and one by 45 degrees in their common plane
            for (j = 0; j < 3; j++)
            begin
                cv[j]     = row[0][j];
                row[0][j] = ((cv[j] + row[1][j]) * DIAG_AXIS) / UNIT_AXIS;
                row[1][j] = ((row[1][j] - cv[j]) * DIAG_AXIS) / UNIT_AXIS;
                cv[j]     = rand_span(-(longint'(1) << 17), longint'(1) << 17);
            end
        end
        else if (style == 3)
        begin
            for (i = 0; i < 3; i++)
                for (j = 0; j < 3; j++)
                    row[i][j] = rand_span(-UNIT_AXIS, UNIT_AXIS);
        end
        else if (style == 4)
        begin
            for (i = 0; i < 3; i++)
            begin
                cv[i] = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
                case ($urandom_range(0, 2))
                    0: ev[i] = EXTENT_MAX;
                    1: ev[i] = COORD_MAX;
                    default: ev[i] = 0;
                endcase
                for (j = 0; j < 3; j++)
                    case ($urandom_range(0, 3))
                        0: row[i][j] = AXIS_MAX;
                        1: row[i][j] = AXIS_MIN;
                        2: row[i][j] = UNIT_AXIS;
                        default: row[i][j] = 0;
                    endcase
            end
        end
        raw_center  = pack_coords(cv[0], cv[1], cv[2]);
        raw_extents = pack_coords(ev[0], ev[1], ev[2]);
        if (style == 5)
        begin
            // Raw bits everywhere
            raw_center  = CFG_DATA_W'({$urandom, $urandom});
            raw_extents = CFG_DATA_W'({$urandom, $urandom});
            for (i = 0; i < 3; i++)
                for (j = 0; j < 3; j++)
                    row[i][j] = rand_span(AXIS_MIN, AXIS_MAX);
        end
        load_box(raw_center, raw_extents,
                 pack_axis(row[0][0], row[0][1], row[0][2]),
                 pack_axis(row[1][0], row[1][1], row[1][2]),
                 pack_axis(row[2][0], row[2][1], row[2][2]));
        if ($urandom_range(0, 3) == 0)
        begin
            spare = CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI));
            write_reg(spare, CFG_DATA_W'({$urandom, $urandom}));
        end
    endtask

    // Queue random queries. Half land around the box so both sides of every face
    // and the containment flag get exercised; the rest are raw, extreme or small.
    task automatic add_random_queries(int count, bit gappy);
        query_t q;
        longint pt [3];
        longint span;
        longint widest;
        int     n;
        int     j;
        int     mode;
        int     pace;
        widest = extent_of(0);
        for (j = 1; j < 3; j++)
            if (extent_of(j) > widest)
                widest = extent_of(j);
        for (n = 0; n < count; n++)
        begin
            mode = $urandom_range(0, 19);
            for (j = 0; j < 3; j++)
            begin
                if (mode < 10)
                begin
                    span = ((mode < 5) ? widest : 2 * widest) + 32;
                    if (span > COORD_MAX)
                        span = COORD_MAX;
                    pt[j] = center_of(j) + rand_span(-span, span);
                end
                else if (mode < 14)
                    pt[j] = rand_span(COORD_MIN, COORD_MAX);
                else if (mode < 17)
                    pt[j] = pick_coord_extreme();
                else
                    pt[j] = rand_span(-512, 512);
            end
            q = mk_query(1'($urandom_range(0, 1)), pt[0], pt[1], pt[2]);
            if (gappy)
            begin
                pace = $urandom_range(0, 99);
                if (pace < 70)
                    q.gap = 0;
                else if (pace < 95)
                    q.gap = $urandom_range(1, 3);
                else
                    q.gap = $urandom_range(8, 40);
            end
            q.drain = ($urandom_range(0, 99) == 0);
            query_backlog.push_back(q);
        end
    endtask

    // Block until every queued transaction is accepted and every result is back,
    // then let the pipeline settle before touching the registers.
    task automatic wait_idle();
        do
            @(negedge clk);
        while (query_backlog.size() != 0 || start || expected_points.size() != 0);
        repeat (PIPE_DEPTH + 4) @(posedge clk);
    endtask

    // ---------------------------------------------------------------------------
    // Driver: predict each accepted transaction at its accept edge, then present
    // the next queued one after its gap. Idle cycles carry noise on the payload.
    // ---------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && !(start && busy))
        begin
            if (start)
                expected_points.push_back(predict_query(active_query));
            launch = 1'b0;
            if (query_backlog.size() != 0)
            begin
                if (!gap_loaded)
                begin
                    gap_left   = query_backlog[0].gap;
                    gap_loaded = 1'b1;
                end
                if (gap_left > 0)
                    gap_left--;
                else if (!query_backlog[0].drain || expected_points.size() == 0)
                begin
                    active_query = query_backlog.pop_front();
                    gap_loaded   = 1'b0;
                    launch       = 1'b1;
                end
            end
            start <= launch;
            if (launch)
            begin
                operation <= active_query.op;
                vec_x     <= active_query.x;
                vec_y     <= active_query.y;
                vec_z     <= active_query.z;
            end
            else
            begin
                operation <= 1'($urandom_range(0, 1));
                vec_x     <= COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
                vec_y     <= COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
                vec_z     <= COORD_W'($urandom_range(0, (1 << COORD_W) - 1));
            end
        end
    end

    // ---------------------------------------------------------------------------
    // Monitor: every done cycle is one result; match it against the oldest
    // prediction field by field.
    // ---------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_points.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual (%0d, %0d, %0d) inside %b",
                         $time, point_x, point_y, point_z, inside_res);
                mismatch_count++;
            end
            else
            begin
                want_point = expected_points.pop_front();
                if (point_x !== want_point.x)
                begin
                    $display("%0t: point_x expected %0d actual %0d", $time, want_point.x, point_x);
                    mismatch_count++;
                end
                if (point_y !== want_point.y)
                begin
                    $display("%0t: point_y expected %0d actual %0d", $time, want_point.y, point_y);
                    mismatch_count++;
                end
                if (point_z !== want_point.z)
                begin
                    $display("%0t: point_z expected %0d actual %0d", $time, want_point.z, point_z);
                    mismatch_count++;
                end
                if (inside_res !== want_point.in_box)
                begin
                    $display("%0t: inside_res expected %b actual %b",
                             $time, want_point.in_box, inside_res);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: a hang or a lost result ends the run here
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------
    // Sequence: directed boxes and queries first, then random boxes with bursts
    // of random queries. Registers change only between phases, once drained.
    // ---------------------------------------------------------------------------
    initial
    begin
        int     phase;
        query_t q;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset box: degenerate, zero center and zero extents
        query_backlog.push_back(mk_query(OP_CLOSEST, 0, 0, 0));
        query_backlog.push_back(mk_query(OP_CLOSEST, 5, -3, 7));
        query_backlog.push_back(mk_query(OP_SUPPORT, 1, 1, 1));
        wait_idle();

        // Axis-aligned box: inside, on the corner, just outside, far out, supports
        load_box(pack_coords(100 * ONE, -50 * ONE, 25 * ONE),
                 pack_coords(10 * ONE, 5 * ONE, 2 * ONE),
                 pack_axis(UNIT_AXIS, 0, 0), pack_axis(0, UNIT_AXIS, 0),
                 pack_axis(0, 0, UNIT_AXIS));
        query_backlog.push_back(mk_query(OP_CLOSEST, 100 * ONE, -50 * ONE, 25 * ONE));
        query_backlog.push_back(mk_query(OP_CLOSEST, 110 * ONE, -45 * ONE, 27 * ONE));
        query_backlog.push_back(mk_query(OP_CLOSEST, 110 * ONE + 1, -50 * ONE, 25 * ONE));
        q = mk_query(OP_CLOSEST, -2000 * ONE, 1000 * ONE, -500 * ONE);
        q.drain = 1'b1; // hold off until the pipeline is empty
        query_backlog.push_back(q);
        query_backlog.push_back(mk_query(OP_SUPPORT, 0, 0, 0));
        query_backlog.push_back(mk_query(OP_SUPPORT, -1, -1, -1));
        query_backlog.push_back(mk_query(OP_SUPPORT, 1, -3, 0));
        wait_idle();

        // Extreme center and extents with the top bit set: saturation on every axis
        load_box(pack_coords(COORD_MAX, COORD_MAX, COORD_MIN),
                 pack_coords(EXTENT_MAX, EXTENT_MAX, EXTENT_MAX),
                 pack_axis(UNIT_AXIS, 0, 0), pack_axis(0, UNIT_AXIS, 0),
                 pack_axis(0, 0, UNIT_AXIS));
        query_backlog.push_back(mk_query(OP_SUPPORT, 1, 1, -1));
        query_backlog.push_back(mk_query(OP_SUPPORT, -1, -1, 1));
        query_backlog.push_back(mk_query(OP_CLOSEST, COORD_MIN, COORD_MAX, COORD_MAX));
        query_backlog.push_back(mk_query(OP_CLOSEST, COORD_MAX, COORD_MIN, COORD_MIN));
        wait_idle();

        // Non-unit and degenerate axes, plus writes past the register list
        load_box(pack_coords(0, 0, 0), pack_coords(3 * ONE, 4 * ONE, 5 * ONE),
                 pack_axis(AXIS_MAX, AXIS_MIN, 0), pack_axis(0, 0, 0),
                 pack_axis(DIAG_AXIS, 0, DIAG_AXIS));
        write_reg(REG_SPARE_LO, CFG_DATA_W'({$urandom, $urandom}));
        write_reg(REG_SPARE_HI, '1);
        query_backlog.push_back(mk_query(OP_CLOSEST, COORD_MAX, COORD_MIN, COORD_MAX));
        query_backlog.push_back(mk_query(OP_SUPPORT, COORD_MIN, COORD_MIN, COORD_MIN));
        query_backlog.push_back(mk_query(OP_CLOSEST, 0, 0, 0));
        query_backlog.push_back(mk_query(OP_SUPPORT, 0, 0, 0));
        wait_idle();

        // Random boxes; every third burst runs back to back with no gaps
        for (phase = 0; phase < 8; phase++)
        begin
            load_random_box();
            add_random_queries(125, (phase % 3) != 0);
            wait_idle();
        end

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/obbq_pkg.sv
hw/rtl/obbq_mac3.sv
hw/rtl/obb_point_query.sv
dv/obb_point_query_tb.sv
